// ----- rtl/hbkr_pkg.sv -----
package hbkr_pkg;

    localparam int NUM_REGS        = 8;
    localparam int REG_IDX_W       = 3;
    localparam int REG_W           = 4;
    localparam int SCAN_W          = 9;
    localparam int HOST_W          = 16;
    localparam int MOD_W           = 8;
    localparam int CODE_W          = 8;
    localparam int NUM_SLOTS       = 6;
    localparam int KEY_COUNT_DEF   = 102;
    localparam int REPORT_KEYS_DEF = 6;

    localparam logic [SCAN_W-1:0] MOD_FIRST = 9'd224;
    localparam logic [SCAN_W-1:0] MOD_LAST  = 9'd231;

    localparam logic [CODE_W-1:0] ROLLOVER_CODE = 8'h01;
    localparam logic [CODE_W-1:0] EMPTY_CODE    = 8'h00;

    typedef logic [NUM_REGS-1:0][REG_W-1:0] mod_pos_t;
    typedef logic [NUM_SLOTS-1:0][CODE_W-1:0] slots_t;

    // Modifier byte bits: left ctrl, shift, alt, gui, then right ctrl, shift, alt, gui.
    localparam mod_pos_t REG_RESET = {4'd11, 4'd9, 4'd1, 4'd7, 4'd10, 4'd8, 4'd0, 4'd6};

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic start;
        logic wr_en;
        logic wr_val;
    } scan_ctrl_t;

    typedef struct packed {
        logic busy;
    } scan_stat_t;

endpackage

// ----- rtl/hid_boot_keyboard_report_builder.sv -----
// Builds a 7-byte boot keyboard report for each key event on the input channel.
// An input request carries a scan code, a press flag and the host modifier word.
// Codes below KEY_COUNT update the pressed-key map; codes 224 to 231 leave it
// unchanged; any other code yields a response with accepted low and zero fields.
// Each report lists up to six pressed keys in ascending order, or the rollover
// code in each slot below REPORT_KEYS when more than REPORT_KEYS keys are down.
// A known code runs the key map scan, which reads one key per cycle and ends
// early once rollover is found, before its response is loaded; an ignored code
// goes straight to the hold state. The next request is accepted the cycle after
// the response is loaded, so a new request is never taken while one is in flight.
// The response sits in an output register; if the receiver stalls, a finished
// report waits in the hold state until that register is free.
// Reset clears the key map and returns the modifier position registers to
// their defaults. Configuration writes take effect at once and are expected
// only while the block is idle.
module hid_boot_keyboard_report_builder
    import hbkr_pkg::*;
#(
    parameter int KEY_COUNT   = KEY_COUNT_DEF,
    parameter int REPORT_KEYS = REPORT_KEYS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [SCAN_W-1:0]    scan_code,
    input  logic                 key_down,
    input  logic [HOST_W-1:0]    host_modifiers,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 accepted,
    output logic [MOD_W-1:0]     modifier_byte,
    output logic [CODE_W-1:0]    key_slot_0,
    output logic [CODE_W-1:0]    key_slot_1,
    output logic [CODE_W-1:0]    key_slot_2,
    output logic [CODE_W-1:0]    key_slot_3,
    output logic [CODE_W-1:0]    key_slot_4,
    output logic [CODE_W-1:0]    key_slot_5
);

    localparam int IDX_W = $clog2(KEY_COUNT);

    state_t             state_reg;
    state_t             state_next;
    mod_pos_t           pos_reg;
    logic               known_reg;
    logic [MOD_W-1:0]   mod_byte_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               acc_out_reg;
    logic [MOD_W-1:0]   mod_out_reg;
    slots_t             slot_out_reg;
    logic               is_key;
    logic               is_mod;
    logic               take;
    logic               load_out;
    logic [MOD_W-1:0]   remap_byte;
    scan_ctrl_t         scan_ctrl;
    scan_stat_t         scan_stat;
    slots_t             scan_slots;

    assign is_key = (scan_code < SCAN_W'(KEY_COUNT));
    assign is_mod = (scan_code >= MOD_FIRST) && (scan_code <= MOD_LAST);
    assign take   = in_valid && in_ready;

    hbkr_remap u_remap
    (
        .host     (host_modifiers),
        .pos      (pos_reg),
        .mod_byte (remap_byte)
    );

    hbkr_keymap #(
        .KEY_COUNT   (KEY_COUNT),
        .REPORT_KEYS (REPORT_KEYS)
    ) u_keymap
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (scan_ctrl),
        .wr_idx (scan_code[IDX_W-1:0]),
        .stat   (scan_stat),
        .slots  (scan_slots)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (is_key || is_mod) ? ST_SCAN : ST_HOLD;
                end
            end
            ST_SCAN:
            begin
                if (!scan_stat.busy)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        load_out         = 1'b0;
        scan_ctrl.start  = 1'b0;
        scan_ctrl.wr_en  = 1'b0;
        scan_ctrl.wr_val = key_down;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                scan_ctrl.start = in_valid && (is_key || is_mod);
                scan_ctrl.wr_en = in_valid && is_key;
            end
            ST_SCAN:
            begin
            end
            ST_HOLD:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= REG_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                pos_reg[cfg_index] <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            known_reg    <= is_key || is_mod;
            mod_byte_reg <= remap_byte;
        end
        if (load_out)
        begin
            acc_out_reg  <= known_reg;
            mod_out_reg  <= known_reg ? mod_byte_reg : '0;
            slot_out_reg <= known_reg ? scan_slots : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = acc_out_reg;
    assign modifier_byte = mod_out_reg;
    assign key_slot_0    = slot_out_reg[0];
    assign key_slot_1    = slot_out_reg[1];
    assign key_slot_2    = slot_out_reg[2];
    assign key_slot_3    = slot_out_reg[3];
    assign key_slot_4    = slot_out_reg[4];
    assign key_slot_5    = slot_out_reg[5];

    // The key map scan runs only while the sequencer waits for it.
    a_scan_in_scan_state: assert property (@(posedge clk) disable iff (!rst_n)
        scan_stat.busy |-> (state_reg == ST_SCAN))
        else $error("key map scan active outside the scan state");

    // A request leaves the idle state, so no second request is taken next cycle.
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a previous request is in flight");

    // An ignored code always reports all-zero fields.
    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !accepted) |-> ((modifier_byte == '0) && (key_slot_0 == EMPTY_CODE)))
        else $error("ignored request produced nonzero report fields");

    // A response is loaded only when the output register is free or being drained.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("pending response was dropped");

endmodule

// ----- rtl/hbkr_remap.sv -----
module hbkr_remap
    import hbkr_pkg::*;
(
    input  logic [HOST_W-1:0] host,
    input  mod_pos_t          pos,
    output logic [MOD_W-1:0]  mod_byte
);

    always_comb
    begin
        for (int b = 0; b < NUM_REGS; b++)
        begin
            mod_byte[b] = host[pos[b]];
        end
    end

endmodule

// ----- rtl/hbkr_keymap.sv -----
module hbkr_keymap
    import hbkr_pkg::*;
#(
    parameter int KEY_COUNT   = KEY_COUNT_DEF,
    parameter int REPORT_KEYS = REPORT_KEYS_DEF,
    localparam int IDX_W      = $clog2(KEY_COUNT),
    localparam int CNT_W      = $clog2(REPORT_KEYS + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctrl_t       ctrl,
    input  logic [IDX_W-1:0] wr_idx,
    output scan_stat_t       stat,
    output slots_t           slots
);

    logic [KEY_COUNT-1:0] pressed_reg;
    logic [KEY_COUNT-1:0] pressed_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic [IDX_W-1:0]     idx_reg;
    logic [IDX_W-1:0]     idx_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 over_reg;
    logic                 over_next;
    slots_t               slot_reg;
    slots_t               slot_next;

    // Visits one key per cycle; a pressed key takes the next free slot or sets rollover.
    always_comb
    begin
        pressed_next = pressed_reg;
        busy_next    = busy_reg;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        over_next    = over_reg;
        slot_next    = slot_reg;
        if (ctrl.start)
        begin
            if (ctrl.wr_en)
            begin
                pressed_next[wr_idx] = ctrl.wr_val;
            end
            busy_next = 1'b1;
            idx_next  = '0;
            cnt_next  = '0;
            over_next = 1'b0;
            for (int s = 0; s < NUM_SLOTS; s++)
            begin
                slot_next[s] = EMPTY_CODE;
            end
        end
        else if (busy_reg)
        begin
            if (pressed_reg[idx_reg])
            begin
                if (cnt_reg == CNT_W'(REPORT_KEYS))
                begin
                    over_next = 1'b1;
                    busy_next = 1'b0;
                end
                else
                begin
                    for (int s = 0; s < NUM_SLOTS; s++)
                    begin
                        if ((s < REPORT_KEYS) && (cnt_reg == CNT_W'(s)))
                        begin
                            slot_next[s] = CODE_W'(idx_reg);
                        end
                    end
                    cnt_next = CNT_W'(cnt_reg + 1'b1);
                end
            end
            if (idx_reg == IDX_W'(KEY_COUNT - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = IDX_W'(idx_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= '0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            pressed_reg <= pressed_next;
            busy_reg    <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        cnt_reg  <= cnt_next;
        over_reg <= over_next;
        slot_reg <= slot_next;
    end

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (i >= REPORT_KEYS)
            begin
                slots[i] = EMPTY_CODE;
            end
            else if (over_reg)
            begin
                slots[i] = ROLLOVER_CODE;
            end
            else
            begin
                slots[i] = slot_reg[i];
            end
        end
    end

    assign stat.busy = busy_reg;

endmodule
